[src/hrm_pkg.sv]
package hrm_pkg;

  localparam int unsigned FracBits  = 12;
  localparam int unsigned HueRange  = 180;
  localparam int unsigned FullScale = 255;

  // Widths of the rounded reciprocals 255*4096/v and 180*4096/(6*diff).
  localparam int unsigned RsW = 20;
  localparam int unsigned RhW = 17;

  // Raw hue lies in -255..1275.
  localparam int unsigned HrawW  = 12;
  localparam int unsigned SprodW = 8 + RsW;
  localparam int unsigned HprodW = HrawW + RhW + 1;

  typedef enum logic [2:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_VAL_LOW  = 3'd4,
    REG_VAL_HIGH = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_low;
    logic [7:0] sat_high;
    logic [7:0] val_low;
    logic [7:0] val_high;
  } bounds_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0]              v;
    logic [7:0]              diff;
    logic signed [HrawW-1:0] hraw;
  } extract_t;

  typedef struct packed {
    logic [7:0]              v;
    logic [7:0]              diff;
    logic signed [HrawW-1:0] hraw;
    logic [RsW-1:0]          rs;
    logic [RhW-1:0]          rh;
  } recip_t;

  typedef struct packed {
    logic [7:0]               v;
    logic [SprodW-1:0]        sprod;
    logic signed [HprodW-1:0] hprod;
  } prod_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } result_t;

endpackage

[src/hrm_extract.sv]
module hrm_extract (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hrm_pkg::pixel_t   pix_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hrm_pkg::extract_t data_o
);
  import hrm_pkg::*;

  logic       valid_q;
  extract_t   data_q, data_d;
  logic [7:0] max_c, min_c, diff_c;
  logic signed [HrawW-1:0] b_s, g_s, r_s, d_s;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    max_c = (pix_i.blue > pix_i.green) ? pix_i.blue : pix_i.green;
    max_c = (max_c > pix_i.red) ? max_c : pix_i.red;
    min_c = (pix_i.blue < pix_i.green) ? pix_i.blue : pix_i.green;
    min_c = (min_c < pix_i.red) ? min_c : pix_i.red;
    diff_c = max_c - min_c;
    b_s = signed'({{(HrawW-8){1'b0}}, pix_i.blue});
    g_s = signed'({{(HrawW-8){1'b0}}, pix_i.green});
    r_s = signed'({{(HrawW-8){1'b0}}, pix_i.red});
    d_s = signed'({{(HrawW-8){1'b0}}, diff_c});
    data_d.v    = max_c;
    data_d.diff = diff_c;
    // Red wins ties, then green.
    priority if (max_c == pix_i.red) begin
      data_d.hraw = g_s - b_s;
    end else if (max_c == pix_i.green) begin
      data_d.hraw = b_s - r_s + (d_s <<< 1);
    end else begin
      data_d.hraw = r_s - g_s + (d_s <<< 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/hrm_recip.sv]
module hrm_recip (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hrm_pkg::extract_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hrm_pkg::recip_t   data_o
);
  import hrm_pkg::*;

  logic           valid_q;
  recip_t         data_q, data_d;
  logic [RsW-1:0] rs_tab [256];
  logic [RhW-1:0] rh_tab [256];

  // Rounded reciprocal tables; a zero divisor reads as zero.
  assign rs_tab[0] = '0;
  assign rh_tab[0] = '0;
  for (genvar gi = 1; gi < 256; gi++) begin : g_tab
    localparam int unsigned SNum = FullScale << FracBits;
    localparam int unsigned HNum = HueRange << FracBits;
    localparam int unsigned RsVal = (2 * SNum + gi) / (2 * gi);
    localparam int unsigned RhVal = (2 * HNum + 6 * gi) / (12 * gi);
    assign rs_tab[gi] = RsW'(RsVal);
    assign rh_tab[gi] = RhW'(RhVal);
  end

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.v    = data_i.v;
    data_d.diff = data_i.diff;
    data_d.hraw = data_i.hraw;
    data_d.rs   = rs_tab[data_i.v];
    data_d.rh   = rh_tab[data_i.diff];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/hrm_mult.sv]
module hrm_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  hrm_pkg::recip_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output hrm_pkg::prod_t  data_o
);
  import hrm_pkg::*;

  logic  valid_q;
  prod_t data_q, data_d;
  logic signed [RhW:0] rh_s;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rh_s         = signed'({1'b0, data_i.rh});
    data_d.v     = data_i.v;
    data_d.sprod = SprodW'(data_i.diff) * SprodW'(data_i.rs);
    data_d.hprod = HprodW'(data_i.hraw) * HprodW'(rh_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/hrm_finish.sv]
module hrm_finish (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hrm_pkg::prod_t   data_i,
  input  hrm_pkg::bounds_t bounds_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hrm_pkg::result_t data_o
);
  import hrm_pkg::*;

  localparam int unsigned HqW = HprodW + 1 - FracBits;

  logic    valid_q;
  result_t data_q, data_d;
  logic signed [HprodW:0]  hsum;
  logic signed [HqW-1:0]   hq;
  logic [SprodW:0]         ssum;
  logic [7:0]              hue_c, sat_c;
  logic                    pass;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // Arithmetic shift gives floor division for negative hue products.
    hsum = (HprodW+1)'(data_i.hprod) + (HprodW+1)'(signed'(1 << (FracBits - 1)));
    hq   = hsum[HprodW:FracBits];
    if (hq < 0) begin
      hq = hq + HqW'(HueRange);
    end
    hue_c = hq[7:0];
    ssum  = (SprodW+1)'(data_i.sprod) + (SprodW+1)'(1 << (FracBits - 1));
    sat_c = ssum[FracBits+7:FracBits];
    pass  = (hue_c >= bounds_i.hue_low) && (hue_c <= bounds_i.hue_high)
         && (sat_c >= bounds_i.sat_low) && (sat_c <= bounds_i.sat_high)
         && (data_i.v >= bounds_i.val_low) && (data_i.v <= bounds_i.val_high);
    data_d.mask       = pass ? 8'hFF : 8'h00;
    data_d.hue        = hue_c;
    data_d.saturation = sat_c;
    data_d.brightness = data_i.v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/hsv_range_mask.sv]
// An accepted input item passes through the extract, reciprocal, multiply and finish registers to the outputs.
// Throughput: one item per cycle while out_stall_i is low, set by the four-stage register pipeline.
// A stage that holds a stalled item advances again once the stage after it frees.
// Reset clears all stage valid bits and loads the bound registers with
// hue 0..180, saturation 0..255 and value 0..255.
module hsv_range_mask (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] blue_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] mask_o,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] brightness_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import hrm_pkg::*;

  bounds_t  bounds_q;
  pixel_t   pix;
  extract_t s1_data;
  recip_t   s2_data;
  prod_t    s3_data;
  result_t  s4_data;
  logic     in_ready;
  logic     s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.hue_low  <= 8'd0;
      bounds_q.hue_high <= 8'(HueRange);
      bounds_q.sat_low  <= 8'd0;
      bounds_q.sat_high <= 8'(FullScale);
      bounds_q.val_low  <= 8'd0;
      bounds_q.val_high <= 8'(FullScale);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HUE_LOW:  bounds_q.hue_low  <= cfg_data_i;
        REG_HUE_HIGH: bounds_q.hue_high <= cfg_data_i;
        REG_SAT_LOW:  bounds_q.sat_low  <= cfg_data_i;
        REG_SAT_HIGH: bounds_q.sat_high <= cfg_data_i;
        REG_VAL_LOW:  bounds_q.val_low  <= cfg_data_i;
        REG_VAL_HIGH: bounds_q.val_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pix.blue  = blue_i;
  assign pix.green = green_i;
  assign pix.red   = red_i;

  hrm_extract u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .pix_i   (pix),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  hrm_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  hrm_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  hrm_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid),
    .ready_o  (s3_ready),
    .data_i   (s3_data),
    .bounds_i (bounds_q),
    .valid_o  (out_valid_o),
    .ready_i  (!out_stall_i),
    .data_o   (s4_data)
  );

  assign in_stall_o   = !in_ready;
  assign mask_o       = s4_data.mask;
  assign hue_o        = s4_data.hue;
  assign saturation_o = s4_data.saturation;
  assign brightness_o = s4_data.brightness;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import hrm_pkg::*;

  // Register indexes past the last bound register; writes to them must be dropped.
  localparam logic [2:0] IdxSpareLow = 3'd6;
  localparam logic [2:0] IdxSpareTop = 3'd7;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] blue_i = 8'd0;
  logic [7:0] green_i = 8'd0;
  logic [7:0] red_i = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] mask_o;
  logic [7:0] hue_o;
  logic [7:0] saturation_o;
  logic [7:0] brightness_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = 3'd0;
  logic [7:0] cfg_data_i = 8'd0;

  pixel_t      pixel_backlog [$];
  result_t     hsv_expected [$];
  bounds_t     bounds_now = '{8'd0, 8'(HueRange), 8'd0, 8'(FullScale), 8'd0, 8'(FullScale)};
  int unsigned pixels_offered = 0;
  int unsigned pixels_accepted = 0;
  int unsigned send_gap = 0;
  int unsigned result_wait = 0;
  int unsigned fault_count = 0;
  logic        calm = 1'b0;
  logic        long_hold = 1'b0;
  pixel_t      next_px;
  result_t     want_res;
  string       bad_fields;

  pixel_t corner_pixels [$] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00, 24'hFF0000,
    24'h6400FF, 24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h000001, 24'h010000,
    24'hFEFFFF, 24'hFFFEFE, 24'hFEFFFE, 24'h0102FF, 24'h7F8081, 24'hAA55FF,
    24'h5AA5C3, 24'h01FF00, 24'h00FE01
  };

  hsv_range_mask dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mask_o       (mask_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned round_recip(int unsigned num, int unsigned den);
    int unsigned q;
    if (den == 0) return 0;
    q = num / den;
    if (2 * (num % den) >= den) q++;
    return q;
  endfunction

  function automatic result_t hsv_classify(pixel_t px, bounds_t bnd);
    int          b, g, r, vmax, vmin, diff, hraw, hprod, hue;
    int unsigned rs, rh, sat;
    result_t     res;
    b = px.blue;
    g = px.green;
    r = px.red;
    vmax = (b > g) ? b : g;
    vmax = (vmax > r) ? vmax : r;
    vmin = (b < g) ? b : g;
    vmin = (vmin < r) ? vmin : r;
    diff = vmax - vmin;
    rs = round_recip(FullScale << FracBits, vmax);
    rh = round_recip(HueRange << FracBits, 6 * diff);
    sat = (diff * rs + (1 << (FracBits - 1))) >> FracBits;
    if (vmax == r) hraw = g - b;
    else if (vmax == g) hraw = b - r + 2 * diff;
    else hraw = r - g + 4 * diff;
    // Arithmetic shift gives the floor of the rounded product.
    hprod = hraw * int'(rh) + (1 << (FracBits - 1));
    hue = hprod >>> FracBits;
    if (hue < 0) hue += int'(HueRange);
    res.hue = 8'(hue);
    res.saturation = 8'(sat);
    res.brightness = 8'(vmax);
    res.mask = (res.hue >= bnd.hue_low && res.hue <= bnd.hue_high &&
                res.saturation >= bnd.sat_low && res.saturation <= bnd.sat_high &&
                res.brightness >= bnd.val_low && res.brightness <= bnd.val_high)
               ? 8'(FullScale) : 8'd0;
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    logic [7:0] lvl;
    pixel_t     px;
    lvl = 8'($urandom);
    px = 24'($urandom);
    case ($urandom_range(0, 9))
      5: px = {lvl, lvl, lvl};
      6: begin
        px = {lvl, lvl, lvl};
        case ($urandom_range(0, 2))
          0: px.blue = 8'($urandom_range(0, lvl));
          1: px.green = 8'($urandom_range(0, lvl));
          default: px.red = 8'($urandom_range(0, lvl));
        endcase
      end
      7: px = {lvl, lvl ^ 8'($urandom_range(0, 3)), lvl ^ 8'($urandom_range(0, 3))};
      8: px = px & 24'h070707;
      9: px = {$urandom_range(0, 1) ? 8'hFF : 8'h00, px.green,
               $urandom_range(0, 1) ? 8'hFF : 8'h00};
      default: ;
    endcase
    return px;
  endfunction

  task automatic note_fault(string msg);
    if (fault_count < 10) $display("%0t: %s", $time, msg);
    fault_count++;
  endtask

  // Sender: one item on the bus at a time, held until taken, then a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && pixels_accepted < pixels_offered)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pixel_backlog.size() > 0) begin
        next_px = pixel_backlog.pop_front();
        blue_i <= next_px.blue;
        green_i <= next_px.green;
        red_i <= next_px.red;
        in_valid_i <= 1'b1;
        pixels_offered++;
        send_gap = calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stalls for a drawn number of cycles after each result, and throughout long_hold.
  always @(negedge clk_i) begin
    out_stall_i <= long_hold || result_wait > 0;
    if (!long_hold && result_wait > 0) result_wait--;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        hsv_expected.push_back(hsv_classify({blue_i, green_i, red_i}, bounds_now));
        pixels_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        result_wait = calm ? 0 : $urandom_range(0, 3);
        if (hsv_expected.size() == 0) begin
          note_fault($sformatf("unexpected result: mask %0d hue %0d sat %0d val %0d",
                               mask_o, hue_o, saturation_o, brightness_o));
        end else begin
          want_res = hsv_expected.pop_front();
          bad_fields = "";
          if (mask_o !== want_res.mask) bad_fields = {bad_fields, " mask"};
          if (hue_o !== want_res.hue) bad_fields = {bad_fields, " hue"};
          if (saturation_o !== want_res.saturation) bad_fields = {bad_fields, " saturation"};
          if (brightness_o !== want_res.brightness) bad_fields = {bad_fields, " brightness"};
          if (bad_fields != "") begin
            note_fault($sformatf("bad%s: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 bad_fields, want_res.mask, want_res.hue,
                                 want_res.saturation, want_res.brightness,
                                 mask_o, hue_o, saturation_o, brightness_o));
          end
        end
      end
    end
  end

  task automatic write_bound(logic [2:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (reg_idx_e'(idx))
      REG_HUE_LOW:  bounds_now.hue_low = val;
      REG_HUE_HIGH: bounds_now.hue_high = val;
      REG_SAT_LOW:  bounds_now.sat_low = val;
      REG_SAT_HIGH: bounds_now.sat_high = val;
      REG_VAL_LOW:  bounds_now.val_low = val;
      REG_VAL_HIGH: bounds_now.val_high = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_bounds(bounds_t nb);
    write_bound(REG_HUE_LOW, nb.hue_low);
    write_bound(REG_HUE_HIGH, nb.hue_high);
    write_bound(REG_SAT_LOW, nb.sat_low);
    write_bound(REG_SAT_HIGH, nb.sat_high);
    write_bound(REG_VAL_LOW, nb.val_low);
    write_bound(REG_VAL_HIGH, nb.val_high);
    write_bound($urandom_range(0, 1) ? IdxSpareLow : IdxSpareTop, 8'($urandom));
  endtask

  // Waits until all pixels are sent and all expected results are checked, then lets the clock run on.
  task automatic drain_results();
    while (pixel_backlog.size() != 0 || in_valid_i || hsv_expected.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Long output stall while the sender keeps going, so the pipeline backs up.
  initial begin
    while (pixels_accepted < 400) @(posedge clk_i);
    long_hold = 1'b1;
    repeat (64) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    bounds_t     nb;
    logic [7:0]  lo;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (corner_pixels[i]) pixel_backlog.push_back(corner_pixels[i]);
    for (int phase = 0; phase < 10; phase++) begin
      if (phase > 0) begin
        drain_results();
        case (phase)
          1: nb = '{8'd20, 8'd40, 8'd100, 8'd255, 8'd50, 8'd200};
          2: nb = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255};
          3: nb = '{8'd180, 8'd180, 8'd255, 8'd255, 8'd0, 8'd255};
          4: nb = '{8'd150, 8'd30, 8'd200, 8'd10, 8'd255, 8'd0};
          5: nb = '{8'd170, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
          6: nb = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
          default: begin
            lo = 8'($urandom_range(0, 180));
            nb.hue_low = lo;
            nb.hue_high = 8'($urandom_range(lo, 180));
            lo = 8'($urandom);
            nb.sat_low = lo;
            nb.sat_high = 8'($urandom_range(lo, 255));
            lo = 8'($urandom_range(0, 128));
            nb.val_low = lo;
            nb.val_high = 8'($urandom_range(lo, 255));
          end
        endcase
        apply_bounds(nb);
      end
      calm = (phase % 4 == 3);
      repeat (175) pixel_backlog.push_back(random_pixel());
    end
    drain_results();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/hrm_pkg.sv
src/hrm_extract.sv
src/hrm_recip.sv
src/hrm_mult.sv
src/hrm_finish.sv
src/hsv_range_mask.sv
tb/testbench.sv
